// ----- rtl/linear_double_ended_queue_top_assert.svh -----
// Assertion macros used by the deque datapath
`ifndef LINEAR_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define LINEAR_DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define LDQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("deque assertion failed");

// implication checked in the next cycle
`define LDQ_ASSERT_NEXT(lbl, pre, post) \
	`LDQ_ASSERT(lbl, (pre) |=> (post))

`endif

// ----- rtl/ldq_pkg.sv -----
// Package: sizes, opcodes, status codes, the controller state type and the controller/datapath command type
package ldq_pkg;

	localparam int DEPTH = 16;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = $clog2(DEPTH + 1);
	localparam int OFF_W = 5;
	localparam int SW    = ((PW > OFF_W) ? PW : OFF_W) + 1;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_REAR   = 3'd3;
	localparam logic [2:0] OP_PEEK       = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RESP = 2'b10
	} ldq_state_t;

	typedef struct packed {
		logic load;
	} ldq_cmd_t;

endpackage

// ----- rtl/ldq_ctrl.sv -----
// Controller: handshake state machine for request and response beats
module ldq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output ldq_pkg::ldq_cmd_t cmd
);
	import ldq_pkg::*;

	ldq_state_t state_q, state_d;

	// a new beat may enter in the same cycle the held result leaves
	assign out_valid = (state_q == S_RESP);
	assign in_stall  = (state_q == S_RESP) && out_stall;
	assign cmd.load  = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load) state_d = S_RESP;
			end
			S_RESP: begin
				if (cmd.load) state_d = S_RESP;
				else if (!out_stall) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

// ----- rtl/ldq_dpath.sv -----
// Datapath: slot memory, front/rear pointers and the result register
module ldq_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ldq_pkg::ldq_cmd_t         cmd,
	input  logic [2:0]                op,
	input  logic signed [31:0]        push_value,
	input  logic [ldq_pkg::OFF_W-1:0] peek_offset,
	output logic signed [31:0]        read_value,
	output logic [1:0]                status
);
	import ldq_pkg::*;

	`include "linear_double_ended_queue_top_assert.svh"

	// front indexes the first element and rear one past the last; both start at zero
	logic [PW-1:0] front_q, rear_q, front_d, rear_d;
	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic          rd_en_q;
	logic [1:0]    status_q;

	logic          empty;
	logic [SW-1:0] peek_sum;
	logic [1:0]    status_d;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [PW-1:0] front_m1, rear_m1;

	assign empty    = (front_q == rear_q);
	assign front_m1 = front_q - PW'(1);
	assign rear_m1  = rear_q - PW'(1);
	assign peek_sum = SW'(front_q) + SW'(peek_offset);

	always_comb begin
		status_d = ST_OK;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = '0;
		rd_addr  = '0;
		front_d  = front_q;
		rear_d   = rear_q;
		case (op)
			OP_PUSH_FRONT: begin
				if (front_q == '0) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = front_m1[AW-1:0];
					front_d = front_m1;
				end
			end
			OP_PUSH_REAR: begin
				if (rear_q == PW'(DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = rear_q[AW-1:0];
					rear_d  = rear_q + PW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					rd_addr = front_q[AW-1:0];
					front_d = front_q + PW'(1);
				end
			end
			OP_POP_REAR: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rear_m1[AW-1:0];
					rear_d  = rear_m1;
				end
			end
			OP_PEEK: begin
				if (peek_offset == '0) begin
					status_d = ST_RANGE;
				end else if (empty) begin
					status_d = ST_EMPTY;
				end else if (peek_sum > SW'(rear_q)) begin
					status_d = ST_RANGE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(peek_sum - SW'(1));
				end
			end
			default: begin
				// undefined opcodes: no state change, ok with zero data
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load && wr_en) mem[wr_addr] <= push_value;
		if (cmd.load && rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			rear_q   <= '0;
			rd_en_q  <= 1'b0;
			status_q <= ST_OK;
		end else if (cmd.load) begin
			front_q  <= front_d;
			rear_q   <= rear_d;
			rd_en_q  <= rd_en;
			status_q <= status_d;
		end
	end

	assign read_value = rd_en_q ? $signed(rdata_q) : '0;
	assign status     = status_q;

	`LDQ_ASSERT(a_ptr_order, front_q <= rear_q)
	`LDQ_ASSERT(a_rear_bound, rear_q <= PW'(DEPTH))
	`LDQ_ASSERT_NEXT(a_refused_holds, cmd.load && (status_d != ST_OK), $stable(front_q) && $stable(rear_q))
	`LDQ_ASSERT_NEXT(a_push_rear_step, cmd.load && wr_en && (op == OP_PUSH_REAR), rear_q == PW'($past(rear_q) + PW'(1)))
	`LDQ_ASSERT_NEXT(a_data_only_ok, cmd.load, rd_en_q == (status_q == ST_OK && rd_en_q))

endmodule

// ----- rtl/linear_double_ended_queue_top.sv -----
// Deque of DEPTH signed 32-bit slots in a linear array; pointers start at
// slot zero and never wrap. Each request beat yields exactly one response beat
// with a value and a status (ok, no room at that end, empty, offset out of
// range). The response appears the cycle after the request is taken, read from
// the registered port of the slot memory; a new request is taken in the same
// cycle the pending response leaves, so one request per cycle is sustained
// while out_stall stays low.
module linear_double_ended_queue_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                op,
	input  logic signed [31:0]        push_value,
	input  logic [ldq_pkg::OFF_W-1:0] peek_offset,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        read_value,
	output logic [1:0]                status
);
	import ldq_pkg::*;

	ldq_cmd_t cmd;

	ldq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ldq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.push_value  (push_value),
		.peek_offset (peek_offset),
		.read_value  (read_value),
		.status      (status)
	);

endmodule
